### hdl/core_enumeration_rom_parser_assert.svh
// Assertion macros used by the core enumeration ROM parser decoder module.
`ifndef CORE_ENUMERATION_ROM_PARSER_ASSERT_SVH
`define CORE_ENUMERATION_ROM_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CERP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CERP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cerp_pkg.sv
// Package with the constants and types of the core enumeration ROM parser.
`default_nettype none

package cerp_pkg;

    localparam int unsigned MAX_WORDS = 128;
    localparam int unsigned CNT_W     = 8;

    localparam logic [3:0] TYPE_CORE = 4'h1;
    localparam logic [3:0] TYPE_ADDR = 4'h5;
    localparam logic [3:0] TYPE_END  = 4'hF;

    localparam logic [11:0] ID_COMMON = 12'h800;
    localparam logic [11:0] ID_RAM    = 12'h80E;
    localparam logic [11:0] ID_BUS    = 12'h829;
    localparam logic [11:0] ID_MAC    = 12'h812;
    localparam logic [11:0] ID_CM3    = 12'h82A;
    localparam logic [11:0] ID_ARM7   = 12'h825;
    localparam logic [11:0] ID_CR4    = 12'h83E;

    typedef struct packed {
        logic [31:0] common_base;
        logic [11:0] cpu_core_id;
        logic [31:0] cpu_ctl_base;
        logic [31:0] cpu_regs_base;
        logic [31:0] ram_ctl_base;
        logic [31:0] ram_regs_base;
        logic [7:0]  ram_core_rev;
        logic [31:0] bus_core_base;
        logic [7:0]  bus_core_rev;
        logic [31:0] mac_ctl_base;
        logic        ended_by_marker;
    } result_t;

endpackage

`default_nettype wire

### hdl/cerp_in_stage.sv
// Input register that holds one ROM word until the decoder takes it.
`default_nettype none

module cerp_in_stage
    import cerp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        word_valid,
    output logic             word_stall,
    input  wire logic [31:0] rom_word,
    input  wire logic        advance,
    output logic             held_valid,
    output logic [31:0]      held_word
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] word_reg;
    logic        accept;

    // The register can take a new item whenever the held one leaves this cycle.
    assign word_stall = valid_reg && !advance;
    assign accept     = word_valid && !word_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= rom_word;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

`default_nettype wire

### hdl/cerp_decode.sv
// Word decoder with the scan state and the table of found cores.
`default_nettype none

module cerp_decode
    import cerp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic [31:0] word,
    output logic             emit,
    output result_t          result
);

`include "core_enumeration_rom_parser_assert.svh"

    logic [11:0]      cur_core_id_reg,   cur_core_id_next;
    logic [7:0]       cur_core_rev_reg,  cur_core_rev_next;
    logic             pair_pending_reg,  pair_pending_next;
    logic [11:0]      pending_id_reg,    pending_id_next;
    logic [CNT_W-1:0] words_seen_reg,    words_seen_next;
    logic [19:0]      found_common_reg,  found_common_next;
    logic [11:0]      found_cpu_id_reg,  found_cpu_id_next;
    logic [19:0]      found_cpu_ctl_reg, found_cpu_ctl_next;
    logic [19:0]      found_cpu_regs_reg, found_cpu_regs_next;
    logic [19:0]      found_ram_ctl_reg, found_ram_ctl_next;
    logic [19:0]      found_ram_regs_reg, found_ram_regs_next;
    logic [7:0]       found_ram_rev_reg, found_ram_rev_next;
    logic [19:0]      found_bus_base_reg, found_bus_base_next;
    logic [7:0]       found_bus_rev_reg, found_bus_rev_next;
    logic [19:0]      found_mac_ctl_reg, found_mac_ctl_next;

    logic [3:0]       word_type;
    logic [19:0]      page;
    logic             ctl;
    logic [CNT_W-1:0] count_inc;
    logic             is_end;
    logic             at_limit;

    assign word_type = word[3:0];
    assign page      = word[31:12];
    assign ctl       = |word[7:6];
    assign count_inc = words_seen_reg + CNT_W'(1);
    assign is_end    = (word_type == TYPE_END);
    assign at_limit  = (count_inc >= CNT_W'(MAX_WORDS));
    assign emit      = is_end || at_limit;

    always_comb
    begin
        cur_core_id_next    = cur_core_id_reg;
        cur_core_rev_next   = cur_core_rev_reg;
        pair_pending_next   = pair_pending_reg;
        pending_id_next     = pending_id_reg;
        words_seen_next     = words_seen_reg;
        found_common_next   = found_common_reg;
        found_cpu_id_next   = found_cpu_id_reg;
        found_cpu_ctl_next  = found_cpu_ctl_reg;
        found_cpu_regs_next = found_cpu_regs_reg;
        found_ram_ctl_next  = found_ram_ctl_reg;
        found_ram_regs_next = found_ram_regs_reg;
        found_ram_rev_next  = found_ram_rev_reg;
        found_bus_base_next = found_bus_base_reg;
        found_bus_rev_next  = found_bus_rev_reg;
        found_mac_ctl_next  = found_mac_ctl_reg;

        if (!is_end)
        begin
            if (word_type == TYPE_CORE)
            begin
                if (pair_pending_reg)
                begin
                    cur_core_id_next  = pending_id_reg;
                    cur_core_rev_next = word[31:24];
                    pair_pending_next = 1'b0;
                end
                else
                begin
                    pending_id_next   = word[19:8];
                    pair_pending_next = 1'b1;
                end
            end
            else
            begin
                pair_pending_next = 1'b0;
                if (word_type == TYPE_ADDR)
                begin
                    case (cur_core_id_reg)
                        ID_COMMON:
                        begin
                            if (!ctl)
                            begin
                                found_common_next = page;
                            end
                        end
                        ID_CM3, ID_ARM7, ID_CR4:
                        begin
                            found_cpu_id_next = cur_core_id_reg;
                            if (ctl && found_cpu_ctl_reg == '0)
                            begin
                                found_cpu_ctl_next = page;
                            end
                            if (!ctl && found_cpu_regs_reg == '0)
                            begin
                                found_cpu_regs_next = page;
                            end
                        end
                        ID_RAM:
                        begin
                            if (ctl)
                            begin
                                found_ram_ctl_next = page;
                            end
                            else if (found_ram_regs_reg == '0)
                            begin
                                found_ram_regs_next = page;
                            end
                            found_ram_rev_next = cur_core_rev_reg;
                        end
                        ID_BUS:
                        begin
                            if (!ctl)
                            begin
                                found_bus_base_next = page;
                            end
                            found_bus_rev_next = cur_core_rev_reg;
                        end
                        ID_MAC:
                        begin
                            if (ctl)
                            begin
                                found_mac_ctl_next = page;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            words_seen_next = count_inc;
        end

        // Either way of ending a scan clears the scan state for the next one; the table of found cores is kept.
        if (emit)
        begin
            cur_core_id_next  = '0;
            cur_core_rev_next = '0;
            pair_pending_next = 1'b0;
            pending_id_next   = '0;
            words_seen_next   = '0;
        end
    end

    // The table is taken after this word's update; an end word leaves it as it is.
    always_comb
    begin
        result.common_base     = {found_common_next, 12'h000};
        result.cpu_core_id     = found_cpu_id_next;
        result.cpu_ctl_base    = {found_cpu_ctl_next, 12'h000};
        result.cpu_regs_base   = {found_cpu_regs_next, 12'h000};
        result.ram_ctl_base    = {found_ram_ctl_next, 12'h000};
        result.ram_regs_base   = {found_ram_regs_next, 12'h000};
        result.ram_core_rev    = found_ram_rev_next;
        result.bus_core_base   = {found_bus_base_next, 12'h000};
        result.bus_core_rev    = found_bus_rev_next;
        result.mac_ctl_base    = {found_mac_ctl_next, 12'h000};
        result.ended_by_marker = is_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_core_id_reg    <= '0;
            cur_core_rev_reg   <= '0;
            pair_pending_reg   <= 1'b0;
            pending_id_reg     <= '0;
            words_seen_reg     <= '0;
            found_common_reg   <= '0;
            found_cpu_id_reg   <= '0;
            found_cpu_ctl_reg  <= '0;
            found_cpu_regs_reg <= '0;
            found_ram_ctl_reg  <= '0;
            found_ram_regs_reg <= '0;
            found_ram_rev_reg  <= '0;
            found_bus_base_reg <= '0;
            found_bus_rev_reg  <= '0;
            found_mac_ctl_reg  <= '0;
        end
        else if (fire)
        begin
            cur_core_id_reg    <= cur_core_id_next;
            cur_core_rev_reg   <= cur_core_rev_next;
            pair_pending_reg   <= pair_pending_next;
            pending_id_reg     <= pending_id_next;
            words_seen_reg     <= words_seen_next;
            found_common_reg   <= found_common_next;
            found_cpu_id_reg   <= found_cpu_id_next;
            found_cpu_ctl_reg  <= found_cpu_ctl_next;
            found_cpu_regs_reg <= found_cpu_regs_next;
            found_ram_ctl_reg  <= found_ram_ctl_next;
            found_ram_regs_reg <= found_ram_regs_next;
            found_ram_rev_reg  <= found_ram_rev_next;
            found_bus_base_reg <= found_bus_base_next;
            found_bus_rev_reg  <= found_bus_rev_next;
            found_mac_ctl_reg  <= found_mac_ctl_next;
        end
    end

    `CERP_ASSERT_NOW(a_count_below_limit, 1'b1,
        words_seen_reg < CNT_W'(MAX_WORDS), "word count reached the scan limit")
    `CERP_ASSERT_NEXT(a_scan_restart, fire && emit,
        words_seen_reg == '0 && !pair_pending_reg && cur_core_id_reg == '0,
        "scan state not cleared after a result")
    `CERP_ASSERT_NOW(a_cpu_id_known, found_cpu_id_reg != '0,
        found_cpu_id_reg == ID_CM3 || found_cpu_id_reg == ID_ARM7 ||
        found_cpu_id_reg == ID_CR4, "recorded ARM core id is not an ARM core")
    `CERP_ASSERT_NEXT(a_idle_holds_count, !fire,
        $stable(words_seen_reg), "word count moved without an item")

endmodule

`default_nettype wire

### hdl/cerp_out_stage.sv
// Output register that holds one result until the receiver takes it.
`default_nettype none

module cerp_out_stage
    import cerp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_data,
    input  wire logic    result_stall,
    output logic         result_valid,
    output result_t      held,
    output logic         out_free
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Free when empty or when the held result is taken at this edge.
    assign out_free = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign result_valid = valid_reg;
    assign held         = data_reg;

endmodule

`default_nettype wire

### hdl/core_enumeration_rom_parser.sv
// A taken word is held in the input register, decoded from there, and its result is held in the output register.
// Throughput: one ROM word per cycle, limited only by the output register when it is stalled.
// Words that end no scan pass through even while a result waits at the output.
// Reset (rst_n low, asynchronous) clears the valid bits of both stage registers, the scan state
// and the table of found cores; the table otherwise persists from scan to scan.
`default_nettype none

module core_enumeration_rom_parser
    import cerp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        word_valid,
    output logic             word_stall,
    input  wire logic [31:0] rom_word,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [31:0]      common_base,
    output logic [11:0]      cpu_core_id,
    output logic [31:0]      cpu_ctl_base,
    output logic [31:0]      cpu_regs_base,
    output logic [31:0]      ram_ctl_base,
    output logic [31:0]      ram_regs_base,
    output logic [7:0]       ram_core_rev,
    output logic [31:0]      bus_core_base,
    output logic [7:0]       bus_core_rev,
    output logic [31:0]      mac_ctl_base,
    output logic             ended_by_marker
);

    logic        held_valid;
    logic [31:0] held_word;
    logic        advance;
    logic        dec_emit;
    logic        out_free;
    result_t     dec_result;
    result_t     out_result;

    // A word that ends a scan may only move on when the output register has room.
    assign advance = held_valid && (!dec_emit || out_free);

    cerp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .rom_word   (rom_word),
        .advance    (advance),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    cerp_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .word   (held_word),
        .emit   (dec_emit),
        .result (dec_result)
    );

    cerp_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && dec_emit),
        .load_data    (dec_result),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .held         (out_result),
        .out_free     (out_free)
    );

    assign common_base     = out_result.common_base;
    assign cpu_core_id     = out_result.cpu_core_id;
    assign cpu_ctl_base    = out_result.cpu_ctl_base;
    assign cpu_regs_base   = out_result.cpu_regs_base;
    assign ram_ctl_base    = out_result.ram_ctl_base;
    assign ram_regs_base   = out_result.ram_regs_base;
    assign ram_core_rev    = out_result.ram_core_rev;
    assign bus_core_base   = out_result.bus_core_base;
    assign bus_core_rev    = out_result.bus_core_rev;
    assign mac_ctl_base    = out_result.mac_ctl_base;
    assign ended_by_marker = out_result.ended_by_marker;

endmodule

`default_nettype wire
